// ===== hw/rtl/ttnc_pkg.sv =====
// shared constants, types and codes of the terrain tile classifier
`default_nettype none

package ttnc_pkg;

  localparam int TILES_PER_SIDE = 16;
  localparam int GRID_SIDE      = TILES_PER_SIDE + 2;
  localparam int GRID_CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W         = $clog2(GRID_CELLS);

  localparam int COORD_W  = 5;
  localparam int HEIGHT_W = 16;
  localparam int KIND_W   = 16;
  localparam int SOFT_W   = 8;
  localparam int HEPS_W   = 15;
  localparam int TILE_W   = HEIGHT_W + KIND_W + SOFT_W;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = HEPS_W;

  // window side and index width
  localparam int WIN       = 5;
  localparam int WIN_IDX_W = $clog2(WIN);

  typedef logic [COORD_W-1:0]          coord_t;
  typedef logic signed [HEIGHT_W-1:0]  height_t;
  typedef logic [KIND_W-1:0]           kind_t;
  typedef logic [SOFT_W-1:0]           soft_t;
  typedef logic [HEPS_W-1:0]           heps_t;
  typedef logic [ADDR_W-1:0]           addr_t;
  typedef logic [WIN_IDX_W-1:0]        win_idx_t;
  typedef logic [CFG_INDEX_W-1:0]      cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]       cfg_data_t;

  typedef enum logic {
    OP_WRITE    = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

  localparam cfg_index_t CFG_HEIGHT_EPS = 2'd0;
  localparam cfg_index_t CFG_SOFT_EPS   = 2'd1;
  localparam cfg_index_t CFG_TRI_SOFT   = 2'd2;

  localparam heps_t HEIGHT_EPS_RESET = 15'd1;
  localparam soft_t SOFT_EPS_RESET   = 8'd1;
  localparam soft_t TRI_SOFT_RESET   = 8'd26;

  typedef struct packed {
    height_t height;
    kind_t   kind;
    soft_t   softness;
  } tile_t;

  typedef enum logic [2:0] {
    WIN_HOLD,
    WIN_LOAD,
    WIN_ROT_LEFT,
    WIN_ROT_RIGHT,
    WIN_ROT_UP
  } win_op_t;

  typedef struct packed {
    logic skip;
    logic advanced;
    logic variance;
    logic lower;
    logic soft_low;
    logic target_lower;
  } win_flags_t;

  typedef struct packed {
    logic skip;
    logic advanced;
    logic blending;
    logic triplanar;
    logic position_error;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ttnc_if.sv =====
// request and result channel interfaces of the terrain tile classifier
`default_nettype none

interface ttnc_in_if
  import ttnc_pkg::*;
  ();
  logic    valid;
  logic    ready;
  logic    operation;
  coord_t  tile_column;
  coord_t  tile_row;
  height_t tile_height;
  kind_t   tile_kind;
  soft_t   tile_softness;

  modport source (
    output valid, operation, tile_column, tile_row, tile_height, tile_kind, tile_softness,
    input  ready
  );
  modport sink (
    input  valid, operation, tile_column, tile_row, tile_height, tile_kind, tile_softness,
    output ready
  );
endinterface

interface ttnc_out_if
  import ttnc_pkg::*;
  ();
  logic valid;
  logic ready;
  logic skip_raymarching;
  logic advanced_raymarching;
  logic blending;
  logic triplanar;
  logic position_error;

  modport source (
    output valid, skip_raymarching, advanced_raymarching, blending, triplanar,
           position_error,
    input  ready
  );
  modport sink (
    input  valid, skip_raymarching, advanced_raymarching, blending, triplanar,
           position_error,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/terrain_tile_neighbourhood_classifier.sv =====
// terrain tile classifier: tile store, window fetch sequencer and result register
//
// requests arrive on in_ch. a write request stores one tile of the padded grid and
// returns an all-zero result; a write beyond the grid is dropped but still answered.
// a classify request names an interior tile and returns skip, advanced, blending
// and triplanar flags; a tile outside the interior returns position_error alone.
// results leave on out_ch from a result register, one per request, in order.
// a write or a rejected classify goes through S_DONE into the result register, and the
// next request is taken once the sequencer is idle again. a classify fetches a clamped 5x5
// window from the single-port tile store, one word a cycle, then walks the inner 3x3
// for the neighbour marks before its result moves into the result register; the next
// request is taken only once the sequencer is back in idle.
// a request may be accepted while the previous result still waits on out_ch; its own
// result then waits in the sequencer until the result register frees up. reset (rst_n
// low, synchronous) sets the tolerance registers to 1, 1 and 26 and empties the result
// register; the tile store keeps no reset and must be written before it is read. cfg_we
// writes register cfg_index with cfg_data; only the user keeps it to idle, unenforced.
`default_nettype none

module terrain_tile_neighbourhood_classifier
  import ttnc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  ttnc_in_if.sink         in_ch,
  ttnc_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire cfg_index_t cfg_index,
  input  wire cfg_data_t  cfg_data
);

  localparam int MARK_STEPS  = 9;
  localparam int CENTER_STEP = MARK_STEPS / 2;
  localparam int STEP_W      = $clog2(MARK_STEPS);

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LAST,
    S_MARKS,
    S_DONE
  } state_t;

  state_t     state_r,   state_nxt;
  win_idx_t   wx_r,      wx_nxt;
  win_idx_t   wy_r,      wy_nxt;
  step_t      step_r,    step_nxt;
  logic       ld_r,      ld_nxt;
  coord_t     col_r,     col_nxt;
  coord_t     row_r,     row_nxt;
  logic       shared_r,  shared_nxt;
  win_flags_t ctr_r,     ctr_nxt;
  result_t    res_r,     res_nxt;
  logic       out_vld_r, out_vld_nxt;
  result_t    out_res_r, out_res_nxt;

  heps_t      heps_r;
  soft_t      seps_r;
  soft_t      tsoft_r;

  logic       accept;
  logic       in_grid;
  logic       in_interior;
  logic       ram_we;
  addr_t      ram_addr;
  tile_t      ram_wdata;
  tile_t      ram_rdata;
  win_op_t    win_op;
  win_flags_t flags;

  function automatic coord_t clamp_coord(coord_t base, win_idx_t off);
    logic signed [COORD_W+1:0] v;
    v = $signed({2'b00, base}) + $signed({{(COORD_W+2-WIN_IDX_W){1'b0}}, off})
      - $signed((COORD_W+2)'(WIN / 2));
    if (v < 0) begin
      return '0;
    end else if (v > $signed((COORD_W+2)'(GRID_SIDE - 1))) begin
      return COORD_W'(GRID_SIDE - 1);
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic addr_t cell_addr(coord_t col, coord_t row);
    return ADDR_W'(row) * ADDR_W'(GRID_SIDE) + ADDR_W'(col);
  endfunction

  // snake through the inner 3x3 so every neighbour passes the target seat
  function automatic win_op_t step_op(step_t step);
    case (step) inside
      STEP_W'(0), STEP_W'(1), STEP_W'(6), STEP_W'(7): return WIN_ROT_LEFT;
      STEP_W'(2), STEP_W'(5):                         return WIN_ROT_UP;
      STEP_W'(3), STEP_W'(4):                         return WIN_ROT_RIGHT;
      default:                                        return WIN_HOLD;
    endcase
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_grid     = (int'(in_ch.tile_column) < GRID_SIDE) && (int'(in_ch.tile_row) < GRID_SIDE);
  assign in_interior = (in_ch.tile_column != '0) && (in_ch.tile_row != '0)
                    && (int'(in_ch.tile_column) <= TILES_PER_SIDE)
                    && (int'(in_ch.tile_row) <= TILES_PER_SIDE);

  assign ram_we    = accept && (in_ch.operation == OP_WRITE) && in_grid;
  assign ram_wdata = '{height: in_ch.tile_height, kind: in_ch.tile_kind,
                       softness: in_ch.tile_softness};
  assign ram_addr  = ram_we ? cell_addr(in_ch.tile_column, in_ch.tile_row)
                            : cell_addr(clamp_coord(col_r, wx_r), clamp_coord(row_r, wy_r));

  assign win_op = ld_r                  ? WIN_LOAD
                : (state_r == S_MARKS)  ? step_op(step_r)
                :                         WIN_HOLD;

  ttnc_ram #(
    .WIDTH (TILE_W),
    .DEPTH (GRID_CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  ttnc_window u_window (
    .clk                (clk),
    .op                 (win_op),
    .load_tile          (ram_rdata),
    .height_eps         (heps_r),
    .softness_eps       (seps_r),
    .triplanar_softness (tsoft_r),
    .flags              (flags)
  );

  always_comb begin
    logic shared_any;

    state_nxt   = state_r;
    wx_nxt      = wx_r;
    wy_nxt      = wy_r;
    step_nxt    = step_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    shared_nxt  = shared_r;
    ctr_nxt     = ctr_r;
    res_nxt     = res_r;
    out_res_nxt = out_res_r;
    ld_nxt      = (state_r == S_READ);
    out_vld_nxt = out_vld_r && !out_ch.ready;
    shared_any  = shared_r || ((int'(step_r) != CENTER_STEP) && flags.target_lower);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          if (in_ch.operation == OP_WRITE) begin
            state_nxt = S_DONE;
          end else if (in_interior) begin
            col_nxt   = in_ch.tile_column;
            row_nxt   = in_ch.tile_row;
            wx_nxt    = '0;
            wy_nxt    = '0;
            state_nxt = S_READ;
          end else begin
            res_nxt.position_error = 1'b1;
            state_nxt              = S_DONE;
          end
        end
      end
      S_READ: begin
        if (int'(wx_r) == WIN - 1) begin
          wx_nxt = '0;
          if (int'(wy_r) == WIN - 1) begin
            state_nxt = S_LAST;
          end else begin
            wy_nxt = wy_r + 1'b1;
          end
        end else begin
          wx_nxt = wx_r + 1'b1;
        end
      end
      S_LAST: begin
        step_nxt   = '0;
        shared_nxt = 1'b0;
        state_nxt  = S_MARKS;
      end
      S_MARKS: begin
        // window is unrotated on the first step, so the centre flags are taken then
        if (step_r == '0) begin
          ctr_nxt = flags;
        end
        shared_nxt = shared_any;
        if (int'(step_r) == MARK_STEPS - 1) begin
          res_nxt.skip           = ctr_r.skip;
          res_nxt.advanced       = ctr_r.advanced;
          res_nxt.blending       = ctr_r.variance;
          res_nxt.triplanar      = ctr_r.variance
                                && ((ctr_r.lower && shared_any) || ctr_r.soft_low);
          res_nxt.position_error = 1'b0;
          state_nxt              = S_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          out_res_nxt = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ld_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ld_r      <= ld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    wx_r      <= wx_nxt;
    wy_r      <= wy_nxt;
    step_r    <= step_nxt;
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    shared_r  <= shared_nxt;
    ctr_r     <= ctr_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heps_r  <= HEIGHT_EPS_RESET;
      seps_r  <= SOFT_EPS_RESET;
      tsoft_r <= TRI_SOFT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEIGHT_EPS: heps_r  <= cfg_data[HEPS_W-1:0];
        CFG_SOFT_EPS:   seps_r  <= cfg_data[SOFT_W-1:0];
        CFG_TRI_SOFT:   tsoft_r <= cfg_data[SOFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid                = out_vld_r;
  assign out_ch.skip_raymarching     = out_res_r.skip;
  assign out_ch.advanced_raymarching = out_res_r.advanced;
  assign out_ch.blending             = out_res_r.blending;
  assign out_ch.triplanar            = out_res_r.triplanar;
  assign out_ch.position_error       = out_res_r.position_error;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after taking a request");

  a_store_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE))
    else $error("tile store written outside idle");

  a_load_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    ld_r |-> ($past(state_r) == S_READ))
    else $error("window load without a store read in the previous cycle");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && (!out_vld_r || out_ch.ready)) |=> (out_vld_r && (state_r == S_IDLE)))
    else $error("finished result not moved into the result register");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ttnc_ram.sv =====
// generic single-port ram with registered read
`default_nettype none

module ttnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ttnc_window.sv =====
// 5x5 tile window: shift-in load, rotation and neighbourhood tests
`default_nettype none

module ttnc_window
  import ttnc_pkg::*;
(
  input  wire logic       clk,
  input  wire win_op_t    op,
  input  wire tile_t      load_tile,
  input  wire heps_t      height_eps,
  input  wire soft_t      softness_eps,
  input  wire soft_t      triplanar_softness,
  output      win_flags_t flags
);

  localparam int CTR = WIN / 2;
  localparam int TGT = 1;
  localparam int DW  = HEIGHT_W + 1;

  tile_t win_r   [WIN][WIN];
  tile_t win_nxt [WIN][WIN];

  function automatic logic signed [DW-1:0] eps_ext(heps_t eps);
    return $signed({{(DW-HEPS_W){1'b0}}, eps});
  endfunction

  function automatic logic signed [DW-1:0] height_ext(height_t h);
    return $signed({h[HEIGHT_W-1], h});
  endfunction

  // window fill, then rotations that bring each tile of the inner 3x3 to the target seat
  always_comb begin
    int nc;
    int nr;
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN; c++) begin
        nc = (c == WIN - 1) ? 0 : c + 1;
        nr = (r == WIN - 1) ? 0 : r + 1;
        case (op)
          WIN_LOAD: begin
            if (c != WIN - 1) begin
              win_nxt[r][c] = win_r[r][nc];
            end else if (r != WIN - 1) begin
              win_nxt[r][c] = win_r[nr][0];
            end else begin
              win_nxt[r][c] = load_tile;
            end
          end
          WIN_ROT_LEFT:  win_nxt[r][c] = win_r[r][nc];
          WIN_ROT_RIGHT: win_nxt[r][c] = win_r[r][(c == 0) ? WIN - 1 : c - 1];
          WIN_ROT_UP:    win_nxt[r][c] = win_r[nr][c];
          default:       win_nxt[r][c] = win_r[r][c];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  // centre tile tests over its 8 neighbours
  always_comb begin
    tile_t                 me;
    tile_t                 nb;
    tile_t                 tg;
    logic signed [DW-1:0]  thr;
    logic signed [DW-1:0]  thr_t;
    logic signed [DW-1:0]  d;
    logic signed [DW-1:0]  e;
    logic                  same;
    logic                  higher_hard;
    logic                  any_lower;
    logic                  any_var;
    logic                  enclosed;
    logic                  corner_any;
    logic                  tgt_lower;
    logic [2:0]            edge_cnt;

    me         = win_r[CTR][CTR];
    e          = eps_ext(height_eps);
    thr        = height_ext(me.height) - e;
    any_lower  = 1'b0;
    any_var    = 1'b0;
    enclosed   = 1'b1;
    for (int r = CTR - 1; r <= CTR + 1; r++) begin
      for (int c = CTR - 1; c <= CTR + 1; c++) begin
        if (!(r == CTR && c == CTR)) begin
          nb          = win_r[r][c];
          d           = height_ext(nb.height) - height_ext(me.height);
          same        = (d < e) && (d > -e);
          higher_hard = (nb.height > me.height) && (nb.softness < softness_eps);
          if (height_ext(nb.height) < thr) begin
            any_lower = 1'b1;
          end
          if ((d > e) || (d < -e) || (nb.kind != me.kind)) begin
            any_var = 1'b1;
          end
          if (!same && !higher_hard) begin
            enclosed = 1'b0;
          end
        end
      end
    end

    edge_cnt = {2'b00, height_ext(win_r[CTR-1][CTR].height) < thr}
             + {2'b00, height_ext(win_r[CTR][CTR-1].height) < thr}
             + {2'b00, height_ext(win_r[CTR][CTR+1].height) < thr}
             + {2'b00, height_ext(win_r[CTR+1][CTR].height) < thr};
    corner_any = (height_ext(win_r[CTR-1][CTR-1].height) < thr)
              || (height_ext(win_r[CTR-1][CTR+1].height) < thr)
              || (height_ext(win_r[CTR+1][CTR-1].height) < thr)
              || (height_ext(win_r[CTR+1][CTR+1].height) < thr);

    // lower mark of whichever tile sits in the target seat
    tg        = win_r[TGT][TGT];
    thr_t     = height_ext(tg.height) - e;
    tgt_lower = 1'b0;
    for (int r = TGT - 1; r <= TGT + 1; r++) begin
      for (int c = TGT - 1; c <= TGT + 1; c++) begin
        if (!(r == TGT && c == TGT)) begin
          if (height_ext(win_r[r][c].height) < thr_t) begin
            tgt_lower = 1'b1;
          end
        end
      end
    end

    flags.skip         = (me.softness <= softness_eps) || enclosed;
    flags.advanced     = (edge_cnt > 3'd1) || ((edge_cnt == 3'd1) && corner_any);
    flags.variance     = any_var;
    flags.lower        = any_lower;
    flags.soft_low     = me.softness < triplanar_softness;
    flags.target_lower = tgt_lower;
  end

endmodule

`default_nettype wire

// ===== bench/ttnc_test_pkg.sv =====
// tile grid predictor and result scoreboard for the terrain tile classifier test
package ttnc_test_pkg;
  import ttnc_pkg::*;

  typedef struct packed {
    op_t     operation;
    coord_t  column;
    coord_t  row;
    height_t height;
    kind_t   kind;
    soft_t   softness;
  } tile_request_t;

  typedef struct {
    tile_request_t request;
    result_t       flags;
  } pending_flags_t;

  class tile_flag_scoreboard;
    tile_t          grid [GRID_SIDE][GRID_SIDE];
    int             height_eps;
    int             soft_eps;
    int             tri_soft;
    pending_flags_t pending_q [$];
    int             failures;
    int             writes;
    int             classified;
    int             rejected;
    int             skips;
    int             advanced;
    int             blended;
    int             triplanar;

    function new();
      height_eps = HEIGHT_EPS_RESET;
      soft_eps   = SOFT_EPS_RESET;
      tri_soft   = TRI_SOFT_RESET;
    endfunction

    function void set_config(int heps, int seps, int tsoft);
      height_eps = heps;
      soft_eps   = seps;
      tri_soft   = tsoft;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function int height_at(int c, int r);
      return int'($signed(grid[r][c].height));
    endfunction

    function int clamp_coord(int v);
      if (v < 0) return 0;
      if (v > GRID_SIDE - 1) return GRID_SIDE - 1;
      return v;
    endfunction

    // lower and variance marks over the clamped 3x3 window of (c, r)
    function void tile_marks(int c, int r, output bit lower, output bit variance);
      int h;
      int nh;
      int nc;
      int nr;
      lower    = 1'b0;
      variance = 1'b0;
      h = height_at(c, r);
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          if (dx != 0 || dy != 0) begin
            nc = clamp_coord(c + dx);
            nr = clamp_coord(r + dy);
            nh = height_at(nc, nr);
            if (nh < h - height_eps) lower = 1'b1;
            if (nh - h > height_eps || h - nh > height_eps ||
                grid[nr][nc].kind != grid[r][c].kind) variance = 1'b1;
          end
        end
      end
    endfunction

    function result_t classify_tile(int c, int r);
      result_t res;
      int      h;
      int      s;
      int      d;
      int      nh;
      int      lower_edges;
      int      lower_corners;
      bit      enclosed;
      bit      same;
      bit      higher_hard;
      bit      my_lower;
      bit      my_var;
      bit      shared;
      bit      nl;
      bit      nv;
      res = '0;
      h = height_at(c, r);
      s = int'(grid[r][c].softness);
      enclosed = 1'b1;
      lower_edges = 0;
      lower_corners = 0;
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          if (dx != 0 || dy != 0) begin
            nh = height_at(c + dx, r + dy);
            d = nh - h;
            same = (d < height_eps) && (-d < height_eps);
            higher_hard = (nh > h) && (int'(grid[r + dy][c + dx].softness) < soft_eps);
            if (!same && !higher_hard) enclosed = 1'b0;
            if (nh < h - height_eps) begin
              if (dx == 0 || dy == 0) lower_edges++;
              else lower_corners++;
            end
          end
        end
      end
      res.skip = (s <= soft_eps) || enclosed;
      res.advanced = (lower_edges > 1) || (lower_edges == 1 && lower_corners != 0);
      tile_marks(c, r, my_lower, my_var);
      // a lower tile shares its slope when any neighbour is lower than its own ring
      shared = 1'b0;
      if (my_var && my_lower) begin
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            if (dx != 0 || dy != 0) begin
              tile_marks(c + dx, r + dy, nl, nv);
              if (nl) shared = 1'b1;
            end
          end
        end
      end
      res.blending  = my_var;
      res.triplanar = my_var && (shared || s < tri_soft);
      return res;
    endfunction

    function void note_request(tile_request_t rq);
      pending_flags_t p;
      p.request = rq;
      p.flags   = '0;
      if (rq.operation == OP_WRITE) begin
        if (rq.column < GRID_SIDE && rq.row < GRID_SIDE) begin
          grid[rq.row][rq.column] = '{height: rq.height, kind: rq.kind,
                                      softness: rq.softness};
          writes++;
        end
      end else if (rq.column < 1 || rq.column > TILES_PER_SIDE ||
                   rq.row < 1 || rq.row > TILES_PER_SIDE) begin
        p.flags.position_error = 1'b1;
        rejected++;
      end else begin
        p.flags = classify_tile(rq.column, rq.row);
        classified++;
        skips     += p.flags.skip;
        advanced  += p.flags.advanced;
        blended   += p.flags.blending;
        triplanar += p.flags.triplanar;
      end
      pending_q.push_back(p);
    endfunction

    function void check_result(result_t got);
      pending_flags_t p;
      if (pending_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result with no request outstanding: skip %b adv %b blend %b tri %b err %b",
                   got.skip, got.advanced, got.blending, got.triplanar, got.position_error);
        return;
      end
      p = pending_q.pop_front();
      if (got !== p.flags) begin
        failures++;
        if (failures <= 10)
          $display({"flag mismatch, %s (%0d,%0d): expected skip %b adv %b blend %b tri %b ",
                    "err %b, got skip %b adv %b blend %b tri %b err %b"},
                   (p.request.operation == OP_WRITE) ? "write" : "classify",
                   p.request.column, p.request.row,
                   p.flags.skip, p.flags.advanced, p.flags.blending, p.flags.triplanar,
                   p.flags.position_error,
                   got.skip, got.advanced, got.blending, got.triplanar, got.position_error);
      end
    endfunction
  endclass

endpackage

// ===== bench/terrain_tile_neighbourhood_classifier_test.sv =====
// self-checking test of the terrain tile classifier with random idling and back-pressure
module terrain_tile_neighbourhood_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ttnc_pkg::*;
  import ttnc_test_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SEGMENT_ITEMS   = 230;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 600;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;

  int   send_idle_pct = 9;
  int   recv_idle_pct = 83;
  logic hold_results = 1'b0;
  logic pressure_armed = 1'b0;
  int   cycle_count = 0;

  tile_flag_scoreboard flags_sb = new();

  ttnc_in_if  in_ch ();
  ttnc_out_if out_ch ();

  terrain_tile_neighbourhood_classifier uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("terrain_tile_neighbourhood_classifier_test failed");
    $finish;
  end

  function automatic tile_request_t write_request(int c, int r, height_t h, kind_t k,
                                                  soft_t s);
    return '{operation: OP_WRITE, column: coord_t'(c), row: coord_t'(r),
             height: h, kind: k, softness: s};
  endfunction

  // the tile payload is unused on classify, so it carries noise
  function automatic tile_request_t classify_request(int c, int r);
    return '{operation: OP_CLASSIFY, column: coord_t'(c), row: coord_t'(r),
             height: height_t'($urandom), kind: kind_t'($urandom),
             softness: soft_t'($urandom)};
  endfunction

  // softness near the thresholds that currently matter
  function automatic soft_t pick_softness();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return soft_t'(flags_sb.soft_eps);
      2:       return soft_t'(flags_sb.soft_eps + 1);
      3:       return soft_t'(flags_sb.soft_eps - 1);
      4:       return soft_t'(flags_sb.tri_soft - 1);
      5:       return soft_t'(flags_sb.tri_soft);
      default: return soft_t'($urandom);
    endcase
  endfunction

  task automatic send_request(tile_request_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= rq.operation;
    in_ch.tile_column   <= rq.column;
    in_ch.tile_row      <= rq.row;
    in_ch.tile_height   <= rq.height;
    in_ch.tile_kind     <= rq.kind;
    in_ch.tile_softness <= rq.softness;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    flags_sb.note_request(rq);
  endtask

  // result side: check on handshake, then pick the next ready
  initial begin
    result_t seen;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        seen = '{skip: out_ch.skip_raymarching, advanced: out_ch.advanced_raymarching,
                 blending: out_ch.blending, triplanar: out_ch.triplanar,
                 position_error: out_ch.position_error};
        flags_sb.check_result(seen);
      end
      out_ch.ready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off so the block backs up and stalls its requests
  initial begin
    wait (pressure_armed === 1'b1);
    @(posedge clk);
    hold_results <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_results <= 1'b0;
  end

  initial begin
    int      sent;
    int      pick;
    int      c;
    int      r;
    int      wc;
    int      wr;
    int      heps;
    int      delta;
    int      new_heps;
    int      new_seps;
    int      new_tsoft;
    height_t centre;
    kind_t   seq_kind;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_HEIGHT_EPS;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= OP_WRITE;
    in_ch.tile_column   <= '0;
    in_ch.tile_row      <= '0;
    in_ch.tile_height   <= '0;
    in_ch.tile_kind     <= '0;
    in_ch.tile_softness <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // flat soft grid first, so no tile is ever read before it is written
    for (int row = 0; row < GRID_SIDE; row++)
      for (int col = 0; col < GRID_SIDE; col++)
        send_request(write_request(col, row, '0, '0, soft_t'(128)));

    // enclosed by equal tiles, then a hard tile
    send_request(classify_request(4, 4));
    send_request(write_request(4, 4, '0, '0, '0));
    send_request(classify_request(4, 4));
    // towering tile with extreme fields, and its neighbour looking up at it
    send_request(write_request(8, 8, height_t'(32767), kind_t'(16'hffff), soft_t'(255)));
    send_request(classify_request(8, 8));
    send_request(classify_request(7, 8));
    // single lower edge with lower corners, soft enough for triplanar
    send_request(write_request(12, 12, height_t'(256), '0, soft_t'(10)));
    send_request(write_request(12, 11, height_t'(256), '0, soft_t'(128)));
    send_request(write_request(11, 12, height_t'(256), '0, soft_t'(128)));
    send_request(write_request(13, 12, height_t'(256), '0, soft_t'(128)));
    send_request(classify_request(12, 12));
    // padding corners feed the clamped windows of the interior corners
    send_request(write_request(0, 0, height_t'(-32768), kind_t'(1), '0));
    send_request(classify_request(1, 1));
    send_request(write_request(17, 17, height_t'(-32768), kind_t'(16'hffff), soft_t'(255)));
    send_request(classify_request(16, 16));
    // writes beyond the grid and classifies outside the interior
    send_request(write_request(18, 3, height_t'(16'h7f00), kind_t'(16'h1234), soft_t'(99)));
    send_request(write_request(3, 31, height_t'(16'h8001), kind_t'(16'h4321), soft_t'(7)));
    send_request(classify_request(0, 5));
    send_request(classify_request(17, 9));
    send_request(classify_request(5, 18));
    send_request(classify_request(31, 31));

    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 83;
        recv_idle_pct <= 9;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      if (seg != 0) begin
        case (seg)
          1: begin new_heps = 0; new_seps = 0; new_tsoft = 0; end
          2: begin new_heps = 32767; new_seps = 255; new_tsoft = 255; end
          3: begin new_heps = 64; new_seps = 40; new_tsoft = 128; end
          4: begin
            new_heps  = $urandom_range(1, 600);
            new_seps  = $urandom_range(0, 255);
            new_tsoft = $urandom_range(0, 255);
          end
          default: begin new_heps = 256; new_seps = 1; new_tsoft = 26; end
        endcase
        // registers change only once every result is back
        in_ch.valid <= 1'b0;
        while (flags_sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HEIGHT_EPS;
        cfg_data  <= cfg_data_t'(new_heps);
        @(posedge clk);
        cfg_index <= CFG_SOFT_EPS;
        cfg_data  <= cfg_data_t'(new_seps);
        @(posedge clk);
        cfg_index <= CFG_TRI_SOFT;
        cfg_data  <= cfg_data_t'(new_tsoft);
        @(posedge clk);
        cfg_we <= 1'b0;
        flags_sb.set_config(new_heps, new_seps, new_tsoft);
      end
      if (seg == 4) pressure_armed <= 1'b1;

      sent = 0;
      while (sent < SEGMENT_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          // reshape the neighbourhood of one tile, then classify it
          c = $urandom_range(1, TILES_PER_SIDE);
          r = $urandom_range(1, TILES_PER_SIDE);
          seq_kind = $urandom_range(1) ? '0 : kind_t'($urandom_range(0, 3));
          if ($urandom_range(9) < 6) begin
            centre = ($urandom_range(3) == 0) ? height_t'($urandom)
                                              : height_t'($urandom_range(0, 2047) - 1024);
            send_request(write_request(c, r, centre, seq_kind, pick_softness()));
            sent++;
          end else begin
            centre = flags_sb.grid[r][c].height;
          end
          heps = flags_sb.height_eps;
          repeat ($urandom_range(0, 6)) begin
            wc = c - 2 + int'($urandom_range(0, 4));
            wr = r - 2 + int'($urandom_range(0, 4));
            wc = (wc < 0) ? 0 : (wc > GRID_SIDE - 1) ? GRID_SIDE - 1 : wc;
            wr = (wr < 0) ? 0 : (wr > GRID_SIDE - 1) ? GRID_SIDE - 1 : wr;
            // heights on either side of the tolerance edges
            case ($urandom_range(0, 9))
              0:       delta = 0;
              1:       delta = 1;
              2:       delta = -1;
              3:       delta = heps;
              4:       delta = -heps;
              5:       delta = heps + 1;
              6:       delta = -heps - 1;
              7:       delta = heps - 1;
              8:       delta = 1 - heps;
              default: delta = int'($urandom_range(0, 2 * heps + 2)) - heps - 1;
            endcase
            send_request(write_request(wc, wr, height_t'(int'(centre) + delta),
                                       ($urandom_range(4) == 0) ? kind_t'($urandom) : seq_kind,
                                       pick_softness()));
            sent++;
          end
          send_request(classify_request(c, r));
          sent++;
          if ($urandom_range(3) == 0) begin
            wc = c - 1 + int'($urandom_range(0, 2));
            wr = r - 1 + int'($urandom_range(0, 2));
            wc = (wc < 1) ? 1 : (wc > TILES_PER_SIDE) ? TILES_PER_SIDE : wc;
            wr = (wr < 1) ? 1 : (wr > TILES_PER_SIDE) ? TILES_PER_SIDE : wr;
            send_request(classify_request(wc, wr));
            sent++;
          end
        end else if (pick < 85) begin
          // stray write anywhere in the coordinate space, full-range contents
          wc = $urandom_range(0, 31);
          wr = $urandom_range(0, 31);
          send_request(write_request(wc, wr, height_t'($urandom), kind_t'($urandom),
                                     soft_t'($urandom)));
          if (wc < GRID_SIDE && wr < GRID_SIDE) sent++;
        end else if (pick < 93) begin
          send_request(classify_request($urandom_range(1, TILES_PER_SIDE),
                                        $urandom_range(1, TILES_PER_SIDE)));
          sent++;
        end else begin
          wc = $urandom_range(1) ? 0 : $urandom_range(TILES_PER_SIDE + 1, 31);
          wr = $urandom_range(0, 31);
          if ($urandom_range(1))
            send_request(classify_request(wc, wr));
          else
            send_request(classify_request(wr, wc));
          sent++;
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (flags_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d tile writes, %0d interior classifies, %0d outside the interior",
             flags_sb.writes, flags_sb.classified, flags_sb.rejected);
    $display("over six tolerance settings; flags set: skip %0d advanced %0d blend %0d tri %0d",
             flags_sb.skips, flags_sb.advanced, flags_sb.blended, flags_sb.triplanar);
    if (flags_sb.failures == 0) begin
      $display("terrain_tile_neighbourhood_classifier_test passed");
    end else begin
      $display("%0d failing results", flags_sb.failures);
      $display("terrain_tile_neighbourhood_classifier_test failed");
    end
    $finish;
  end

endmodule
